>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MPTB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define MPTB_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/mptb_pkg.sv
package mptb_pkg;

    localparam int MAX_CPUS_DEF = 64;
    // Slot and count width covers the whole MAX_CPUS range (up to 255).
    localparam int SLOT_W       = 8;
    localparam int HDR_BYTES    = 44;
    localparam logic [31:0] MAX_LEN = 32'd65535;

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SIG   = 2'd1;
    localparam logic [1:0] ST_BAD_CKSUM = 2'd2;
    localparam logic [1:0] ST_BAD_LEN   = 2'd3;

    // Lookup query traveling down the cell chain.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [7:0]        query;
        logic [SLOT_W-1:0] index;
    } token_t;

    // Broadcast from the parser to every cell.
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [7:0]        wr_data;
        logic              rsv_en;
        logic [SLOT_W-1:0] rsv_slot;
        logic              clr_pend;
        logic [SLOT_W-1:0] cpu_count;
    } cell_ctrl_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [6:0] total;
        logic [5:0] index;
        logic       found;
    } result_t;

    // Expected signature "APIC".
    function automatic logic [7:0] sig_byte(input logic [1:0] pos);
        logic [7:0] val;
        case (pos)
            2'd0:    val = 8'h41;
            2'd1:    val = 8'h50;
            2'd2:    val = 8'h49;
            2'd3:    val = 8'h43;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/core/mptb_cell.sv
module mptb_cell #(
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mptb_pkg::cell_ctrl_t ctrl,
    input  mptb_pkg::token_t     tok_in,
    output mptb_pkg::token_t     tok_out
);

    localparam int SW = mptb_pkg::SLOT_W;
    localparam logic [SW-1:0] MY_SLOT = SW'(INDEX);

    logic [7:0]       id_reg;
    logic [7:0]       id_next;
    logic             pend_reg;
    logic             pend_next;
    mptb_pkg::token_t tok_reg;
    mptb_pkg::token_t tok_next;
    logic             wr_hit;
    logic             match;

    assign wr_hit = ctrl.wr_en && (ctrl.wr_slot == MY_SLOT);

    always_comb
    begin
        id_next = wr_hit ? ctrl.wr_data : id_reg;
    end

    // A reserved slot stays hidden from lookups until its id byte lands.
    always_comb
    begin
        if (ctrl.clr_pend)
            pend_next = 1'b0;
        else if (ctrl.rsv_en && (ctrl.rsv_slot == MY_SLOT))
            pend_next = 1'b1;
        else if (wr_hit)
            pend_next = 1'b0;
        else
            pend_next = pend_reg;
    end

    assign match = tok_in.valid && !tok_in.found && !pend_reg &&
                   (id_reg == tok_in.query) && (MY_SLOT < ctrl.cpu_count);

    // Claim the query on first match; later cells see it already found.
    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.found = 1'b1;
            tok_next.index = MY_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/core/mptb_parser.sv
module mptb_parser #(
    parameter int MAX_CPUS = mptb_pkg::MAX_CPUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_en,
    input  logic [7:0]                        table_byte,
    input  logic                              first_byte,
    output mptb_pkg::cell_ctrl_t              ctrl,
    output logic                              emit_valid,
    output mptb_pkg::result_t                 emit_res,
    output logic [mptb_pkg::SLOT_W-1:0]       cpu_count
);

    localparam int SW = mptb_pkg::SLOT_W;
    localparam logic [SW-1:0] MAX_SLOT = SW'(MAX_CPUS);
    localparam logic [15:0] HDR_OFF = 16'(mptb_pkg::HDR_BYTES);
    localparam logic [31:0] HDR_LEN = 32'(mptb_pkg::HDR_BYTES);

    logic [15:0]   off_reg,   off_next;
    logic [31:0]   len_reg,   len_next;
    logic [7:0]    sum_reg,   sum_next;
    logic          sig_reg,   sig_next;
    logic          act_reg,   act_next;
    logic [15:0]   epos_reg,  epos_next;
    logic [16:0]   esize_reg, esize_next;
    logic          stop_reg,  stop_next;
    logic [SW-1:0] cnt_reg,   cnt_next;
    logic [3:0]    pv_reg,    pv_next;
    logic [SW-1:0] ps_reg  [4];
    logic [SW-1:0] ps_next [4];

    logic [15:0]   cur_off;
    logic [1:0]    cur_lane;
    logic [1:0]    rsv_lane;
    logic [2:0]    npend;
    logic [1:0]    fin_status;

    always_comb
    begin
        off_next   = off_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        sig_next   = sig_reg;
        act_next   = act_reg;
        epos_next  = epos_reg;
        esize_next = esize_reg;
        stop_next  = stop_reg;
        cnt_next   = cnt_reg;
        pv_next    = pv_reg;
        ps_next    = ps_reg;
        cur_off    = '0;
        cur_lane   = '0;
        rsv_lane   = '0;
        npend      = '0;
        fin_status = mptb_pkg::ST_OK;
        ctrl       = '0;
        emit_valid = 1'b0;
        emit_res   = '0;

        if (byte_en)
        begin
            if (first_byte)
            begin
                off_next      = '0;
                len_next      = '0;
                sum_next      = '0;
                sig_next      = 1'b1;
                act_next      = 1'b1;
                epos_next     = '1;
                esize_next    = 17'(mptb_pkg::HDR_BYTES);
                stop_next     = 1'b0;
                cnt_next      = '0;
                pv_next       = '0;
                ctrl.clr_pend = 1'b1;
            end

            if (act_next)
            begin
                cur_off  = off_next;
                cur_lane = cur_off[1:0];
                rsv_lane = cur_lane + 2'd3;
                sum_next = sum_next + table_byte;

                if (cur_off < 16'd4)
                begin
                    if (table_byte != mptb_pkg::sig_byte(cur_lane))
                        sig_next = 1'b0;
                end
                else if (cur_off < 16'd8)
                begin
                    len_next = len_next | (32'(table_byte) << {cur_lane, 3'b000});
                    if ((cur_off == 16'd7) &&
                        ((len_next < HDR_LEN) || (len_next > mptb_pkg::MAX_LEN)))
                    begin
                        act_next        = 1'b0;
                        cnt_next        = '0;
                        pv_next         = '0;
                        ctrl.clr_pend   = 1'b1;
                        emit_valid      = 1'b1;
                        emit_res.kind   = mptb_pkg::KIND_STATUS;
                        emit_res.status = mptb_pkg::ST_BAD_LEN;
                    end
                end

                if (cur_off >= 16'd8)
                begin
                    // Land a reserved id byte in its slot.
                    if (pv_next[cur_lane])
                    begin
                        ctrl.wr_en      = 1'b1;
                        ctrl.wr_slot    = ps_next[cur_lane];
                        ctrl.wr_data    = table_byte;
                        pv_next[cur_lane] = 1'b0;
                    end

                    if ((cur_off >= HDR_OFF) && (32'(cur_off) < len_next))
                    begin
                        if (cur_off == epos_next)
                        begin
                            esize_next = {1'b0, cur_off} - 17'd1 + 17'(table_byte);
                            if (table_byte == 8'd0)
                                stop_next = 1'b1;
                        end
                        if (!stop_next && ({1'b0, cur_off} == esize_next))
                        begin
                            epos_next = cur_off + 16'd1;
                            if (table_byte == 8'd0)
                            begin
                                if (cnt_next >= MAX_SLOT)
                                    stop_next = 1'b1;
                                else
                                begin
                                    pv_next[rsv_lane] = 1'b1;
                                    ps_next[rsv_lane] = cnt_next;
                                    ctrl.rsv_en       = 1'b1;
                                    ctrl.rsv_slot     = cnt_next;
                                    cnt_next          = cnt_next + SW'(1);
                                end
                            end
                        end
                    end

                    if ((32'(cur_off) + 32'd1) == len_next)
                    begin
                        // Drop slots whose id byte never arrived.
                        npend = 3'(pv_next[0]) + 3'(pv_next[1]) +
                                3'(pv_next[2]) + 3'(pv_next[3]);
                        if (cnt_next > SW'(npend))
                            cnt_next = cnt_next - SW'(npend);
                        else
                            cnt_next = '0;
                        pv_next       = '0;
                        ctrl.clr_pend = 1'b1;
                        if (!sig_next)
                            fin_status = mptb_pkg::ST_BAD_SIG;
                        else if (sum_next != 8'd0)
                            fin_status = mptb_pkg::ST_BAD_CKSUM;
                        else
                            fin_status = mptb_pkg::ST_OK;
                        if (fin_status != mptb_pkg::ST_OK)
                            cnt_next = '0;
                        act_next        = 1'b0;
                        emit_valid      = 1'b1;
                        emit_res.kind   = mptb_pkg::KIND_STATUS;
                        emit_res.status = fin_status;
                    end
                end

                off_next = cur_off + 16'd1;
            end
        end

        emit_res.total = cnt_next[6:0];
        ctrl.cpu_count = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            sig_reg   <= 1'b0;
            act_reg   <= 1'b0;
            epos_reg  <= '0;
            esize_reg <= '0;
            stop_reg  <= 1'b0;
            cnt_reg   <= '0;
            pv_reg    <= '0;
        end
        else
        begin
            off_reg   <= off_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            sig_reg   <= sig_next;
            act_reg   <= act_next;
            epos_reg  <= epos_next;
            esize_reg <= esize_next;
            stop_reg  <= stop_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ps_reg <= ps_next;
    end

    assign cpu_count = cnt_reg;

endmodule

>>> rtl/core/madt_processor_table_builder_core.sv
// Table byte: one per cycle while s_tready is high; the status result is registered.
// Lookup: the query walks the chain of MAX_CPUS cells, one cell per cycle; no new item
// is accepted until the answer leaves the last cell. A two-entry output stage lets
// input continue while a result waits.
// Reset (rst_n low, asynchronous) clears parse state, count, pending marks and output
// valids; stored APIC ids are left as they are.
`include "assert_macros.svh"

module madt_processor_table_builder_core #(
    parameter int MAX_CPUS = mptb_pkg::MAX_CPUS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] table_byte, [15:8] query_apic_id
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] status, [8:2] cpu_total, [14:9] logical_index,
                                   // [15] found
    output logic [0:0]  m_tuser    // [0] kind
);

    localparam int SW = mptb_pkg::SLOT_W;
    localparam logic [SW-1:0] MAX_SLOT = SW'(MAX_CPUS);

    logic                 accept;
    logic                 byte_en;
    logic                 lk_start;
    mptb_pkg::cell_ctrl_t ctrl;
    logic                 emit_valid;
    mptb_pkg::result_t    emit_res;
    logic [SW-1:0]        cpu_count;
    mptb_pkg::token_t     tok [MAX_CPUS+1];
    mptb_pkg::token_t     tok_end;

    logic                 busy_reg,   busy_next;
    logic                 out_v_reg,  out_v_next;
    logic                 skid_v_reg, skid_v_next;
    mptb_pkg::result_t    out_reg,    out_next;
    mptb_pkg::result_t    skid_reg,   skid_next;
    logic                 push;
    mptb_pkg::result_t    push_res;
    logic                 pop;

    assign s_tready = !skid_v_reg && !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign byte_en  = accept && (s_tuser[0] == mptb_pkg::CMD_BYTE);
    assign lk_start = accept && (s_tuser[0] == mptb_pkg::CMD_LOOKUP);

    mptb_parser #(
        .MAX_CPUS (MAX_CPUS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .table_byte (s_tdata[7:0]),
        .first_byte (s_tuser[1]),
        .ctrl       (ctrl),
        .emit_valid (emit_valid),
        .emit_res   (emit_res),
        .cpu_count  (cpu_count)
    );

    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = lk_start;
        tok[0].query = s_tdata[15:8];
    end

    for (genvar k = 0; k < MAX_CPUS; k++)
    begin : g_cell
        mptb_cell #(
            .INDEX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    assign tok_end = tok[MAX_CPUS];

    always_comb
    begin
        busy_next = busy_reg;
        if (lk_start)
            busy_next = 1'b1;
        else if (tok_end.valid)
            busy_next = 1'b0;
    end

    always_comb
    begin
        push_res = emit_res;
        push     = emit_valid;
        if (tok_end.valid)
        begin
            push            = 1'b1;
            push_res.kind   = mptb_pkg::KIND_LOOKUP;
            push_res.status = mptb_pkg::ST_OK;
            push_res.total  = cpu_count[6:0];
            push_res.index  = tok_end.index[5:0];
            push_res.found  = tok_end.found;
        end
    end

    // Output register with a skid entry behind it.
    assign pop = out_v_reg && m_tready;

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        out_next    = out_reg;
        skid_next   = skid_reg;
        if (pop)
        begin
            if (skid_v_reg)
            begin
                out_next    = skid_reg;
                skid_v_next = 1'b0;
            end
            else
                out_v_next = 1'b0;
        end
        if (push)
        begin
            if (!out_v_next)
            begin
                out_next   = push_res;
                out_v_next = 1'b1;
            end
            else
            begin
                skid_next   = push_res;
                skid_v_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = {out_reg.found, out_reg.index, out_reg.total, out_reg.status};
    assign m_tuser[0] = out_reg.kind;

    `MPTB_ASSERT(a_skid_behind_out, (skid_v_reg |-> out_v_reg), "skid holds data with output empty")
    `MPTB_ASSERT_NEVER(a_lookup_room, (tok_end.valid && skid_v_reg), "lookup answer with no room")
    `MPTB_ASSERT(a_count_cap, (cpu_count <= MAX_SLOT), "processor count above capacity")
    `MPTB_ASSERT(a_found_in_range, ((tok_end.valid && tok_end.found) |-> (tok_end.index < cpu_count)), "lookup index past count")

endmodule
